// File: hw/rtl/text_console_writer_top_defines.svh
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// plain check, off while reset is applied
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check of the cycle after a trigger, off while reset is applied
`define TCW_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/tcw_pkg.sv
package tcw_pkg;

  typedef struct packed {
    logic       opcode;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_column;
    logic       end_of_string;
  } item_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic [15:0] cell_value;
    logic        scrolled;
    logic        string_done;
  } result_t;

  // item opcodes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTRIBUTE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_STEP       = 1'b1;

  // special characters
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [15:0] RESET_CELL     = 16'h0F20;
  localparam logic [7:0]  RESET_ATTR     = 8'h0F;
  localparam logic [6:0]  RESET_TAB_STEP = 7'd8;

  // datapath commands
  localparam int DP_OP_W = 3;
  localparam logic [DP_OP_W-1:0] DP_NOP    = 3'd0;
  localparam logic [DP_OP_W-1:0] DP_LOAD   = 3'd1;
  localparam logic [DP_OP_W-1:0] DP_EXEC   = 3'd2;
  localparam logic [DP_OP_W-1:0] DP_RDOUT  = 3'd3;
  localparam logic [DP_OP_W-1:0] DP_SCROLL = 3'd4;
  localparam logic [DP_OP_W-1:0] DP_CLEAR  = 3'd5;
  localparam logic [DP_OP_W-1:0] DP_INIT   = 3'd6;

  typedef struct packed {
    logic [DP_OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic scroll_due;
    logic is_ff;
    logic sweep_done;
  } status_t;

endpackage

// File: hw/rtl/text_console_writer_top.sv
// channel  | ports                                   | handshake
// ---------+-----------------------------------------+-------------------------------
// input    | start, busy, in_word                    | taken when start & !busy
// result   | out_valid, out_word                     | one-cycle strobe, no back-pressure
// config   | cfg_we, cfg_index, cfg_wdata            | written when cfg_we is high
//
// a plain put holds busy through one execute state against the screen store, its
//   result shown in the cycle after; the next word is taken once back in idle
// a read adds a read return state: the cell comes back in the cycle after the address (registered ram)
// a put that must scroll first runs a row copy sweep and then a second execute
//   state, a form feed runs a blanking sweep
// after reset the store is blanked by a sweep over all ROWS*COLUMNS cells (2000 at 80x25) with busy
//   held high; configuration writes are taken during that pass
// the result side cannot stall: each word is shown for exactly one cycle

`include "text_console_writer_top_defines.svh"

module text_console_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input words
  input  logic                           start,
  output logic                           busy,
  input  tcw_pkg::item_t                 in_word,
  // result words
  output logic                           out_valid,
  output tcw_pkg::result_t               out_word,
  // configuration
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t status;

  // sequencer: one state per phase of a word (execute, read return, sweeps)
  tcw_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // cursor, settings, screen store and result register
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // a result is only ever shown once the sequencer is back in idle
  `TCW_ASSERT(a_out_when_idle, !out_valid || !busy, "result shown while busy")

endmodule

// File: hw/rtl/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/tcw_ctrl.sv
`include "text_console_writer_top_defines.svh"

module tcw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  tcw_pkg::status_t status,
  output tcw_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_RDOUT  = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = tcw_pkg::DP_NOP;
    case (state_r)
      S_INIT: begin
        cmd.op = tcw_pkg::DP_INIT;
        if (status.sweep_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op    = tcw_pkg::DP_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.op = tcw_pkg::DP_EXEC;
        if (status.is_read)         state_nxt = S_RDOUT;
        else if (status.scroll_due) state_nxt = S_SCROLL;
        else if (status.is_ff)      state_nxt = S_CLEAR;
        else                        state_nxt = S_IDLE;
      end
      S_RDOUT: begin
        cmd.op    = tcw_pkg::DP_RDOUT;
        state_nxt = S_IDLE;
      end
      S_SCROLL: begin
        cmd.op = tcw_pkg::DP_SCROLL;
        if (status.sweep_done) state_nxt = S_EXEC;
      end
      S_CLEAR: begin
        cmd.op = tcw_pkg::DP_CLEAR;
        if (status.sweep_done) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `TCW_ASSERT_NEXT(a_start_to_exec, start && !busy, state_r == S_EXEC, "accepted word not executed")
  `TCW_ASSERT_NEXT(a_scroll_resumes, state_r == S_SCROLL && status.sweep_done, state_r == S_EXEC, "put not resumed after scroll")

endmodule

// File: hw/rtl/tcw_datapath.sv
`include "text_console_writer_top_defines.svh"

module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tcw_pkg::cmd_t                    cmd,
  output tcw_pkg::status_t                 status,
  input  tcw_pkg::item_t                   in_word,
  input  logic                             cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                             out_valid,
  output tcw_pkg::result_t                 out_word
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int SW    = AW + 8;

  tcw_pkg::item_t   item_r, item_nxt;
  tcw_pkg::result_t out_word_r, out_word_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [6:0]       col_r, col_nxt;
  logic [7:0]       attr_r, attr_nxt;
  logic [6:0]       tab_r, tab_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             scrolled_r, scrolled_nxt;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [15:0]      ram_wdata, ram_rdata;

  logic [SW-1:0]    put_lin, rd_lin;
  logic             rd_ok;
  logic [6:0]       step;
  logic [7:0]       tab_sum, inc_sum;
  logic [15:0]      blank;
  logic             is_ctrl;

  tcw_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    put_lin = SW'(row_r) * SW'(COLUMNS) + SW'(col_r);
    rd_lin  = SW'(item_r.read_row) * SW'(COLUMNS) + SW'(item_r.read_column);
    rd_ok   = (SW'(item_r.read_row) < SW'(ROWS)) && (SW'(item_r.read_column) < SW'(COLUMNS));
    step    = (SW'(tab_r) > SW'(COLUMNS - 1)) ? 7'(COLUMNS - 1) : tab_r;
    tab_sum = {1'b0, col_r} + {1'b0, step};
    inc_sum = {1'b0, col_r} + 8'd1;
    blank   = {attr_r, tcw_pkg::CH_SPACE};
    is_ctrl = (item_r.char_code == tcw_pkg::CH_TAB) || (item_r.char_code == tcw_pkg::CH_NL) ||
              (item_r.char_code == tcw_pkg::CH_CR)  || (item_r.char_code == tcw_pkg::CH_FF);

    status.is_read    = (item_r.opcode == tcw_pkg::OP_READ);
    status.scroll_due = (row_r == RW'(ROWS));
    status.is_ff      = (item_r.char_code == tcw_pkg::CH_FF);
    status.sweep_done = (cmd.op == tcw_pkg::DP_SCROLL) ? (cnt_r == CW'(CELLS))
                                                       : (cnt_r == CW'(CELLS - 1));
  end

  always_comb begin
    item_nxt      = item_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = 1'b0;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cnt_nxt       = cnt_r;
    scrolled_nxt  = scrolled_r;
    attr_nxt      = attr_r;
    tab_nxt       = tab_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = blank;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    if (cfg_we) begin
      case (cfg_index)
        tcw_pkg::CFG_TEXT_ATTRIBUTE: attr_nxt = cfg_wdata;
        tcw_pkg::CFG_TAB_STEP:       tab_nxt  = cfg_wdata[6:0];
        default: ;
      endcase
    end

    case (cmd.op)
      tcw_pkg::DP_LOAD: begin
        item_nxt     = in_word;
        scrolled_nxt = 1'b0;
      end
      tcw_pkg::DP_EXEC: begin
        if (status.is_read) begin
          ram_re    = rd_ok;
          ram_raddr = rd_lin[AW-1:0];
        end else if (!status.scroll_due && !status.is_ff) begin
          // put of a character that is not a form feed, with no scroll due
          case (item_r.char_code)
            tcw_pkg::CH_TAB: begin
              if (tab_sum >= 8'(COLUMNS)) begin
                row_nxt = row_r + RW'(1);
                col_nxt = 7'(tab_sum - 8'(COLUMNS));
              end else begin
                col_nxt = tab_sum[6:0];
              end
            end
            tcw_pkg::CH_NL: begin
              row_nxt = row_r + RW'(1);
              col_nxt = '0;
            end
            tcw_pkg::CH_CR: begin
              col_nxt = '0;
            end
            default: begin
              if (inc_sum == 8'(COLUMNS)) begin
                row_nxt = row_r + RW'(1);
                col_nxt = '0;
              end else begin
                col_nxt = inc_sum[6:0];
              end
            end
          endcase
          ram_we    = !is_ctrl;
          ram_waddr = put_lin[AW-1:0];
          ram_wdata = {attr_r, item_r.char_code};
          out_valid_nxt              = 1'b1;
          out_word_nxt.cursor_row    = 5'(row_nxt);
          out_word_nxt.cursor_column = col_nxt;
          out_word_nxt.cell_value    = '0;
          out_word_nxt.scrolled      = scrolled_r;
          out_word_nxt.string_done   = item_r.end_of_string;
        end
      end
      tcw_pkg::DP_RDOUT: begin
        out_valid_nxt              = 1'b1;
        out_word_nxt.cursor_row    = 5'(row_r);
        out_word_nxt.cursor_column = col_r;
        out_word_nxt.cell_value    = rd_ok ? ram_rdata : 16'd0;
        out_word_nxt.scrolled      = 1'b0;
        out_word_nxt.string_done   = item_r.end_of_string;
      end
      tcw_pkg::DP_SCROLL: begin
        // read one row ahead, write the cell one behind the counter
        ram_re    = (cnt_r < CW'(CELLS - COLUMNS));
        ram_raddr = AW'(cnt_r + CW'(COLUMNS));
        ram_we    = (cnt_r != '0);
        ram_waddr = AW'(cnt_r - CW'(1));
        ram_wdata = (cnt_r <= CW'(CELLS - COLUMNS)) ? ram_rdata : blank;
        if (status.sweep_done) begin
          cnt_nxt      = '0;
          row_nxt      = row_r - RW'(1);
          scrolled_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      tcw_pkg::DP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[AW-1:0];
        ram_wdata = blank;
        if (status.sweep_done) begin
          cnt_nxt                    = '0;
          row_nxt                    = '0;
          col_nxt                    = '0;
          out_valid_nxt              = 1'b1;
          out_word_nxt.cursor_row    = '0;
          out_word_nxt.cursor_column = '0;
          out_word_nxt.cell_value    = '0;
          out_word_nxt.scrolled      = scrolled_r;
          out_word_nxt.string_done   = item_r.end_of_string;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      tcw_pkg::DP_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[AW-1:0];
        ram_wdata = tcw_pkg::RESET_CELL;
        cnt_nxt   = status.sweep_done ? '0 : cnt_r + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      scrolled_r  <= 1'b0;
      attr_r      <= tcw_pkg::RESET_ATTR;
      tab_r       <= tcw_pkg::RESET_TAB_STEP;
    end else begin
      out_valid_r <= out_valid_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      scrolled_r  <= scrolled_nxt;
      attr_r      <= attr_nxt;
      tab_r       <= tab_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `TCW_ASSERT(a_row_bound, SW'(row_r) <= SW'(ROWS), "cursor row beyond pending row")
  `TCW_ASSERT(a_col_bound, SW'(col_r) < SW'(COLUMNS), "cursor column off screen")

endmodule

// File: bench/text_console_writer_top_tb.sv
`timescale 1ns / 1ps

module text_console_writer_top_tb;

  // screen geometry, as built
  localparam int SCREEN_COLS  = 80;
  localparam int SCREEN_ROWS  = 25;
  localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

  // random part: phases of configuration, words per phase
  localparam int PHASES          = 6;
  localparam int WORDS_PER_PHASE = 250;

  // bound on one wait for the block to go quiet, scroll and clear sweeps included
  localparam int SETTLE_LIMIT = 10000;

  // kinds of row in the directed table
  typedef enum logic {
    ROW_WORD,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                             kind;
    tcw_pkg::item_t                        word;
    logic                                  typed;    // expected result written into the row
    tcw_pkg::result_t                      want;
    logic [tcw_pkg::CFG_IDX_W-1:0]         reg_idx;
    logic [tcw_pkg::CFG_DATA_W-1:0]        reg_val;
  } plan_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  tcw_pkg::item_t                 in_word;
  logic                           out_valid;
  tcw_pkg::result_t               out_word;
  logic                           cfg_we;
  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // console image held by the bench: cells, linear cursor and both registers
  logic [15:0] screen_image [0:SCREEN_CELLS-1];
  int unsigned cursor_lin;
  logic [7:0]  attr_reg;
  logic [6:0]  tab_reg;

  tcw_pkg::result_t due_results [$];
  int               fail_count;
  int               mismatch_count;

  plan_row_t   plan [$];

  text_console_writer_top #(
    .COLUMNS (SCREEN_COLS),
    .ROWS    (SCREEN_ROWS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop, several times the slowest legal run
  initial begin
    #150_000_000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // console behaviour: applies one accepted word to the image, gives its result
  // ---------------------------------------------------------------------------
  function automatic tcw_pkg::result_t console_response(tcw_pkg::item_t w);
    tcw_pkg::result_t r;
    int unsigned      row_now;
    int unsigned      advance;
    int               i;
    r = '0;
    if (w.opcode == tcw_pkg::OP_READ) begin
      // anything off the screen reads as zero
      if (w.read_row < SCREEN_ROWS && w.read_column < SCREEN_COLS)
        r.cell_value = screen_image[w.read_row * SCREEN_COLS + w.read_column];
    end else begin
      // cursor parked below the last row: scroll before handling the character
      if (cursor_lin / SCREEN_COLS > SCREEN_ROWS - 1) begin
        for (i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
          screen_image[i] = screen_image[i + SCREEN_COLS];
        for (i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
          screen_image[i] = {attr_reg, tcw_pkg::CH_SPACE};
        cursor_lin -= SCREEN_COLS;
        r.scrolled = 1'b1;
      end
      row_now = cursor_lin / SCREEN_COLS;
      case (w.char_code)
        tcw_pkg::CH_TAB: begin
          // oversized steps are clipped to one short of a full row
          advance = (tab_reg > SCREEN_COLS - 1) ? SCREEN_COLS - 1 : tab_reg;
          cursor_lin += advance;
        end
        tcw_pkg::CH_NL: cursor_lin = (row_now + 1) * SCREEN_COLS;
        tcw_pkg::CH_CR: cursor_lin = row_now * SCREEN_COLS;
        tcw_pkg::CH_FF: begin
          for (i = 0; i < SCREEN_CELLS; i++)
            screen_image[i] = {attr_reg, tcw_pkg::CH_SPACE};
          cursor_lin = 0;
        end
        default: begin
          if (cursor_lin < SCREEN_CELLS)
            screen_image[cursor_lin] = {attr_reg, w.char_code};
          cursor_lin += 1;
        end
      endcase
    end
    r.cursor_row    = 5'(cursor_lin / SCREEN_COLS);
    r.cursor_column = 7'(cursor_lin % SCREEN_COLS);
    r.string_done   = w.end_of_string;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // table rows
  // ---------------------------------------------------------------------------
  function automatic plan_row_t put_row(logic [7:0] ch, logic eos);
    plan_row_t p;
    p = '0;
    p.kind               = ROW_WORD;
    p.word.opcode        = tcw_pkg::OP_PUT;
    p.word.char_code     = ch;
    p.word.end_of_string = eos;
    return p;
  endfunction

  function automatic plan_row_t read_row_at(logic [4:0] r, logic [6:0] c, logic eos);
    plan_row_t p;
    p = '0;
    p.kind               = ROW_WORD;
    p.word.opcode        = tcw_pkg::OP_READ;
    p.word.read_row      = r;
    p.word.read_column   = c;
    p.word.end_of_string = eos;
    return p;
  endfunction

  // read while the cursor is still home, so the whole result is known up front
  function automatic plan_row_t read_at_home(logic [4:0] r, logic [6:0] c, logic eos,
                                             logic [15:0] cell_val);
    plan_row_t p;
    p = read_row_at(r, c, eos);
    p.typed            = 1'b1;
    p.want.cell_value  = cell_val;
    p.want.string_done = eos;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(logic [tcw_pkg::CFG_IDX_W-1:0] idx,
                                        logic [tcw_pkg::CFG_DATA_W-1:0] val);
    plan_row_t p;
    p = '0;
    p.kind    = ROW_CFG;
    p.reg_idx = idx;
    p.reg_val = val;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // random words and gaps
  // ---------------------------------------------------------------------------
  function automatic tcw_pkg::item_t random_word();
    tcw_pkg::item_t w;
    int unsigned    pick;
    int unsigned    cur_row;
    w = tcw_pkg::item_t'($urandom);
    w.end_of_string = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 99) < 30) begin
      w.opcode = tcw_pkg::OP_READ;
      pick = $urandom_range(0, 9);
      if (pick >= 2 && pick <= 5) begin
        // anywhere on the screen
        w.read_row    = 5'($urandom_range(0, SCREEN_ROWS - 1));
        w.read_column = 7'($urandom_range(0, SCREEN_COLS - 1));
      end else if (pick >= 6) begin
        // around the cursor, where the fresh text sits
        cur_row = cursor_lin / SCREEN_COLS;
        if (cur_row > SCREEN_ROWS - 1)
          cur_row = SCREEN_ROWS - 1;
        if (cur_row > 0 && $urandom_range(0, 1) == 1)
          cur_row -= 1;
        w.read_row    = 5'(cur_row);
        w.read_column = 7'($urandom_range(0, SCREEN_COLS - 1));
      end
      // otherwise keep the raw field bits, off-screen included
    end else begin
      w.opcode = tcw_pkg::OP_PUT;
      pick = $urandom_range(0, 999);
      if (pick < 120)
        w.char_code = tcw_pkg::CH_NL;
      else if (pick < 200)
        w.char_code = tcw_pkg::CH_TAB;
      else if (pick < 240)
        w.char_code = tcw_pkg::CH_CR;
      else if (pick < 245)
        w.char_code = tcw_pkg::CH_FF;
      else if (pick < 850)
        w.char_code = 8'($urandom_range(8'h21, 8'h7E));
      else
        w.char_code = 8'($urandom_range(0, 255));
    end
    return w;
  endfunction

  // mostly back to back or short, now and then a long pause
  function automatic int gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      return 0;
    else if (pick < 85)
      return $urandom_range(1, 3);
    else if (pick < 97)
      return $urandom_range(4, 12);
    else
      return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------
  // offers one word from the falling edge, holds it until a rising edge with busy low
  task automatic drive_word(input tcw_pkg::item_t w, input int gap, input logic typed,
                            input tcw_pkg::result_t want);
    tcw_pkg::result_t r;
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   = 1'b1;
    in_word = w;
    do @(posedge clk); while (busy);
    // word taken at this edge
    r = console_response(w);
    due_results.push_back(typed ? want : r);
  endtask

  // drops start, then waits for every result and for busy to fall, with a bound
  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk);
    start = 1'b0;
    while ((due_results.size() != 0 || busy) && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tcw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tcw_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx == tcw_pkg::CFG_TEXT_ATTRIBUTE)
      attr_reg = val;
    else if (idx == tcw_pkg::CFG_TAB_STEP)
      tab_reg = val[6:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result checking: every strobe against the oldest waiting word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tcw_pkg::result_t exp_r;
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: row %0d col %0d cell %h scr %b done %b",
                   out_word.cursor_row, out_word.cursor_column, out_word.cell_value,
                   out_word.scrolled, out_word.string_done);
      end else begin
        exp_r = due_results.pop_front();
        if (out_word.cursor_row !== exp_r.cursor_row ||
            out_word.cursor_column !== exp_r.cursor_column ||
            out_word.cell_value !== exp_r.cell_value ||
            out_word.scrolled !== exp_r.scrolled ||
            out_word.string_done !== exp_r.string_done) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: exp row %0d col %0d cell %h scr %b done %b",
                      " / got row %0d col %0d cell %h scr %b done %b"},
                     exp_r.cursor_row, exp_r.cursor_column, exp_r.cell_value,
                     exp_r.scrolled, exp_r.string_done,
                     out_word.cursor_row, out_word.cursor_column, out_word.cell_value,
                     out_word.scrolled, out_word.string_done);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] phase_attr [PHASES];
    logic [6:0] phase_tab  [PHASES];
    int         i;
    int         n;
    int         gap;

    // every input known from time zero, reset applied first
    rst_n     = 1'b0;
    start     = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_index = tcw_pkg::CFG_TEXT_ATTRIBUTE;
    cfg_wdata = '0;
    fail_count     = 0;
    mismatch_count = 0;

    for (i = 0; i < SCREEN_CELLS; i++)
      screen_image[i] = tcw_pkg::RESET_CELL;
    cursor_lin = 0;
    attr_reg   = tcw_pkg::RESET_ATTR;
    tab_reg    = tcw_pkg::RESET_TAB_STEP;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // let the power-up blanking sweep run out
    settle();

    // directed table: reset image, off-screen reads, control codes, tab extremes, clear
    plan.push_back(read_at_home(5'd0, 7'd0, 1'b0, tcw_pkg::RESET_CELL));
    plan.push_back(read_at_home(5'd24, 7'd79, 1'b1, tcw_pkg::RESET_CELL));
    plan.push_back(read_at_home(5'd31, 7'd127, 1'b0, 16'h0000));
    plan.push_back(read_at_home(5'd25, 7'd0, 1'b1, 16'h0000));
    plan.push_back(read_at_home(5'd0, 7'd80, 1'b0, 16'h0000));
    plan.push_back(put_row(8'h41, 1'b0));
    plan.push_back(put_row(8'h00, 1'b0));
    plan.push_back(put_row(8'hFF, 1'b1));
    plan.push_back(put_row(8'h07, 1'b0));          // bell is just another byte
    plan.push_back(put_row(tcw_pkg::CH_TAB, 1'b0));
    plan.push_back(put_row(tcw_pkg::CH_CR, 1'b0));
    plan.push_back(put_row(tcw_pkg::CH_NL, 1'b0));
    plan.push_back(read_row_at(5'd0, 7'd0, 1'b0));
    plan.push_back(read_row_at(5'd0, 7'd3, 1'b1));
    plan.push_back(cfg_row(tcw_pkg::CFG_TEXT_ATTRIBUTE, 8'hFF));
    plan.push_back(put_row(8'h1B, 1'b0));
    plan.push_back(read_row_at(5'd1, 7'd0, 1'b0));
    plan.push_back(cfg_row(tcw_pkg::CFG_TAB_STEP, 8'd0));   // tab that goes nowhere
    plan.push_back(put_row(tcw_pkg::CH_TAB, 1'b0));
    plan.push_back(cfg_row(tcw_pkg::CFG_TAB_STEP, 8'd127)); // clipped to a row less one
    plan.push_back(put_row(tcw_pkg::CH_TAB, 1'b0));
    plan.push_back(put_row(tcw_pkg::CH_TAB, 1'b1));  // no wrap; the first one wrapped
    plan.push_back(cfg_row(tcw_pkg::CFG_TAB_STEP, 8'd79));
    plan.push_back(put_row(tcw_pkg::CH_TAB, 1'b0));
    plan.push_back(put_row(8'h0B, 1'b0));          // vertical tab is written, not obeyed
    plan.push_back(put_row(tcw_pkg::CH_FF, 1'b0)); // clear in the new attribute
    plan.push_back(read_row_at(5'd24, 7'd79, 1'b1));
    plan.push_back(read_row_at(5'd31, 7'd127, 1'b0));

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        settle();
        write_reg(plan[k].reg_idx, plan[k].reg_val);
      end else begin
        drive_word(plan[k].word, gap_len(), plan[k].typed, plan[k].want);
      end
    end

    // settings for the random phases, extremes first
    phase_attr[0] = 8'h00;                      phase_tab[0] = 7'd1;
    phase_attr[1] = 8'hFF;                      phase_tab[1] = 7'd79;
    phase_attr[2] = 8'($urandom_range(0, 255)); phase_tab[2] = 7'($urandom_range(0, 127));
    phase_attr[3] = tcw_pkg::RESET_ATTR;        phase_tab[3] = 7'd127;
    phase_attr[4] = 8'($urandom_range(0, 255)); phase_tab[4] = 7'd0;
    phase_attr[5] = 8'($urandom_range(0, 255)); phase_tab[5] = 7'($urandom_range(1, 79));

    for (i = 0; i < PHASES; i++) begin
      settle();
      write_reg(tcw_pkg::CFG_TEXT_ATTRIBUTE, phase_attr[i]);
      write_reg(tcw_pkg::CFG_TAB_STEP, {1'b0, phase_tab[i]});
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        // one stretch in four with start held high throughout
        gap = ((n / 50) % 4 == 3) ? 0 : gap_len();
        drive_word(random_word(), gap, 1'b0, '0);
      end
    end

    // drain, then a short tail for stray strobes
    settle();
    repeat (8) @(posedge clk);

    if (fail_count == 0 && due_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
